/* rtl/pcku_pkg.sv */
// shared types, constants and palette function of the color-keyed plasma pixel unit
package pcku_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 16;
    localparam int PHASE_W     = 9;
    localparam int COLOR_W     = 8;
    localparam int SUM_SHIFT   = 4;
    localparam int SUM_W       = (ENTRY_W + 2 > SUM_SHIFT + COLOR_W) ?
                                 ENTRY_W + 2 : SUM_SHIFT + COLOR_W;

    localparam logic [PHASE_W-1:0] COLUMN_STEP   = PHASE_W'(9);
    localparam logic [PHASE_W-1:0] ROW_STEP      = PHASE_W'(8);
    localparam logic [COLOR_W-1:0] PLASMA_OFFSET = COLOR_W'(128);
    localparam logic [COLOR_W-1:0] COLOR_FULL    = COLOR_W'(255);

    typedef enum logic [1:0] {
        ACT_LOAD      = 2'd0,
        ACT_PIXEL     = 2'd1,
        ACT_END_FRAME = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_KEY_RED         = 3'd0,
        REG_KEY_GREEN       = 3'd1,
        REG_KEY_BLUE        = 3'd2,
        REG_FIXED_COL_PHASE = 3'd3,
        REG_FIXED_ROW_PHASE = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        BAND_FALL_RED   = 2'd0,
        BAND_RISE_RED   = 2'd1,
        BAND_FALL_BOTH  = 2'd2,
        BAND_RISE_ONLY  = 2'd3
    } band_t;

    typedef struct packed {
        logic               match;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_stage_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
    } plasma_color_t;

    function automatic logic [SUM_W-1:0] sext_entry(input logic [ENTRY_W-1:0] value);
        sext_entry = {{(SUM_W - ENTRY_W){value[ENTRY_W-1]}}, value};
    endfunction

    function automatic plasma_color_t palette(input logic [COLOR_W-1:0] idx);
        logic [COLOR_W-1:0] up;
        logic [COLOR_W-1:0] quad;
        plasma_color_t      c;
        up   = {idx[COLOR_W-3:0], 2'b01};
        quad = {idx[COLOR_W-3:0], 2'b00};
        case (band_t'(idx[COLOR_W-1:COLOR_W-2]))
            BAND_FALL_RED:
            begin
                c.red   = COLOR_FULL - up;
                c.green = quad;
            end
            BAND_RISE_RED:
            begin
                c.red   = up;
                c.green = COLOR_FULL;
            end
            BAND_FALL_BOTH:
            begin
                c.red   = COLOR_FULL - up;
                c.green = COLOR_FULL - up;
            end
            default:
            begin
                c.red   = up;
                c.green = '0;
            end
        endcase
        palette = c;
    endfunction

endpackage

/* rtl/plasma_color_keyed_pixel_unit.sv */
// color-keyed plasma pixel unit: pattern table, phases, pixel pipeline and register port
// a pixel transaction goes through the read stage and then the output registers; out_stall can hold it
// throughput: one transaction per clock unless stalled; two table copies, two reads each
// load and end-of-frame transactions give no result
// reset clears phases, key and phase registers and pipeline valid flags
// the pattern table is not cleared and holds garbage until loaded
module plasma_color_keyed_pixel_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [8:0]  table_address,
    input  logic signed [15:0] table_value,
    input  logic [9:0]  column,
    input  logic [8:0]  row,
    input  logic [7:0]  pixel_red,
    input  logic [7:0]  pixel_green,
    input  logic [7:0]  pixel_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        replaced
);

    logic [pcku_pkg::ENTRY_W-1:0] table_a_mem [pcku_pkg::TABLE_DEPTH];
    logic [pcku_pkg::ENTRY_W-1:0] table_b_mem [pcku_pkg::TABLE_DEPTH];

    logic [pcku_pkg::COLOR_W-1:0] key_red_reg;
    logic [pcku_pkg::COLOR_W-1:0] key_green_reg;
    logic [pcku_pkg::COLOR_W-1:0] key_blue_reg;
    logic [pcku_pkg::PHASE_W-1:0] fixed_col_phase_reg;
    logic [pcku_pkg::PHASE_W-1:0] fixed_row_phase_reg;
    logic [pcku_pkg::PHASE_W-1:0] moving_col_phase_reg;
    logic [pcku_pkg::PHASE_W-1:0] moving_row_phase_reg;

    logic                         s1_valid_reg;
    pcku_pkg::pixel_stage_t       s1_reg;
    pcku_pkg::pixel_stage_t       s1_next;
    logic [pcku_pkg::ENTRY_W-1:0] rd0_reg;
    logic [pcku_pkg::ENTRY_W-1:0] rd1_reg;
    logic [pcku_pkg::ENTRY_W-1:0] rd2_reg;
    logic [pcku_pkg::ENTRY_W-1:0] rd3_reg;

    logic                         out_valid_reg;
    logic [pcku_pkg::COLOR_W-1:0] out_red_reg;
    logic [pcku_pkg::COLOR_W-1:0] out_green_reg;
    logic [pcku_pkg::COLOR_W-1:0] out_blue_reg;
    logic                         replaced_reg;

    logic                s2_load;
    logic                s1_load;
    logic                in_accept;
    pcku_pkg::action_t   act;
    logic                is_load;
    logic                is_pixel;
    logic                is_end_frame;
    logic                cfg_write;

    logic [pcku_pkg::TABLE_AW-1:0] col9;
    logic [pcku_pkg::TABLE_AW-1:0] col5;
    logic [pcku_pkg::TABLE_AW-1:0] col3;
    logic [pcku_pkg::TABLE_AW-1:0] row3;
    logic [pcku_pkg::TABLE_AW-1:0] addr0;
    logic [pcku_pkg::TABLE_AW-1:0] addr1;
    logic [pcku_pkg::TABLE_AW-1:0] addr2;
    logic [pcku_pkg::TABLE_AW-1:0] addr3;

    logic [pcku_pkg::SUM_W-1:0]   sum;
    logic [pcku_pkg::COLOR_W-1:0] plasma_idx;
    pcku_pkg::plasma_color_t      plasma;

    // handshake
    assign s2_load   = !out_valid_reg || !out_stall;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign in_stall  = !s1_load;
    assign in_accept = in_valid && s1_load;

    assign act          = pcku_pkg::action_t'(action);
    assign is_load      = in_accept && (act == pcku_pkg::ACT_LOAD);
    assign is_pixel     = in_accept && (act == pcku_pkg::ACT_PIXEL);
    assign is_end_frame = in_accept && (act == pcku_pkg::ACT_END_FRAME);

    // table addresses, all mod table depth
    assign col9  = column[pcku_pkg::TABLE_AW-1:0];
    assign col5  = {col9[pcku_pkg::TABLE_AW-3:0], 2'b00} + col9;
    assign col3  = {col9[pcku_pkg::TABLE_AW-2:0], 1'b0} + col9;
    assign row3  = {row[pcku_pkg::TABLE_AW-2:0], 1'b0} + row;
    assign addr0 = moving_col_phase_reg + col5;
    assign addr1 = fixed_col_phase_reg + col3;
    assign addr2 = moving_row_phase_reg + row3;
    assign addr3 = fixed_row_phase_reg + row;

    assign s1_next.match = (pixel_red == key_red_reg) && (pixel_green == key_green_reg) &&
                           (pixel_blue == key_blue_reg);
    assign s1_next.red   = pixel_red;
    assign s1_next.green = pixel_green;
    assign s1_next.blue  = pixel_blue;

    // two identical table copies, two reads each
    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            table_a_mem[table_address] <= $unsigned(table_value);
            table_b_mem[table_address] <= $unsigned(table_value);
        end
        if (s1_load)
        begin
            rd0_reg <= table_a_mem[addr0];
            rd1_reg <= table_a_mem[addr1];
            rd2_reg <= table_b_mem[addr2];
            rd3_reg <= table_b_mem[addr3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= is_pixel;
        end
    end

    // sum, shift and palette
    assign sum = pcku_pkg::sext_entry(rd0_reg) + pcku_pkg::sext_entry(rd1_reg) +
                 pcku_pkg::sext_entry(rd2_reg) + pcku_pkg::sext_entry(rd3_reg);
    assign plasma_idx = sum[pcku_pkg::SUM_SHIFT+pcku_pkg::COLOR_W-1:pcku_pkg::SUM_SHIFT] +
                        pcku_pkg::PLASMA_OFFSET;
    assign plasma     = pcku_pkg::palette(plasma_idx);

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            if (s1_reg.match)
            begin
                out_red_reg   <= plasma.red;
                out_green_reg <= plasma.green;
                out_blue_reg  <= '0;
                replaced_reg  <= 1'b1;
            end
            else
            begin
                out_red_reg   <= s1_reg.red;
                out_green_reg <= s1_reg.green;
                out_blue_reg  <= s1_reg.blue;
                replaced_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign replaced  = replaced_reg;

    // frame phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_col_phase_reg <= '0;
            moving_row_phase_reg <= '0;
        end
        else if (is_end_frame)
        begin
            moving_col_phase_reg <= moving_col_phase_reg + pcku_pkg::COLUMN_STEP;
            moving_row_phase_reg <= moving_row_phase_reg + pcku_pkg::ROW_STEP;
        end
    end

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_red_reg         <= '0;
            key_green_reg       <= '0;
            key_blue_reg        <= '0;
            fixed_col_phase_reg <= '0;
            fixed_row_phase_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (pcku_pkg::reg_index_t'(paddr[4:2]))
                pcku_pkg::REG_KEY_RED:
                    key_red_reg <= pwdata[pcku_pkg::COLOR_W-1:0];
                pcku_pkg::REG_KEY_GREEN:
                    key_green_reg <= pwdata[pcku_pkg::COLOR_W-1:0];
                pcku_pkg::REG_KEY_BLUE:
                    key_blue_reg <= pwdata[pcku_pkg::COLOR_W-1:0];
                pcku_pkg::REG_FIXED_COL_PHASE:
                    fixed_col_phase_reg <= pwdata[pcku_pkg::PHASE_W-1:0];
                pcku_pkg::REG_FIXED_ROW_PHASE:
                    fixed_row_phase_reg <= pwdata[pcku_pkg::PHASE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (pcku_pkg::reg_index_t'(paddr[4:2]))
            pcku_pkg::REG_KEY_RED:         prdata = 32'(key_red_reg);
            pcku_pkg::REG_KEY_GREEN:       prdata = 32'(key_green_reg);
            pcku_pkg::REG_KEY_BLUE:        prdata = 32'(key_blue_reg);
            pcku_pkg::REG_FIXED_COL_PHASE: prdata = 32'(fixed_col_phase_reg);
            pcku_pkg::REG_FIXED_ROW_PHASE: prdata = 32'(fixed_row_phase_reg);
            default:                       prdata = '0;
        endcase
    end

    // checks
    a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
        is_pixel |=> s1_valid_reg)
        else $error("accepted pixel transaction did not enter the read stage");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_load |=> s1_valid_reg && $stable(s1_reg))
        else $error("read stage lost its transaction while blocked");

    a_keyed_blue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && replaced_reg |-> out_blue_reg == '0)
        else $error("replaced pixel has nonzero blue");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        is_end_frame |=> moving_col_phase_reg ==
            pcku_pkg::PHASE_W'($past(moving_col_phase_reg) + pcku_pkg::COLUMN_STEP))
        else $error("column phase did not advance on end of frame");

endmodule
